FILE: rtl/core/dynamic_priority_scheduler_top_assert.svh
// Assertion macros used by the scheduler's checker file, dps_checker.sv.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define DPS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define DPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/dps_pkg.sv
// Types and constants of the dynamic priority scheduler.
`default_nettype none
package dps_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ID_W     = 8;
  localparam int PRI_W    = 16;
  localparam int TIME_W   = 16;
  localparam int STAT_W   = 3;
  localparam int QCOUNT_W = 5;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  localparam logic [STAT_W-1:0] STAT_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REQUEUED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FINISHED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  localparam logic signed [PRI_W-1:0] PRI_MIN = {1'b1, {(PRI_W-1){1'b0}}};

  typedef struct packed {
    logic                    cmd;
    logic [ID_W-1:0]         proc_id;
    logic signed [PRI_W-1:0] priority_req;
    logic [TIME_W-1:0]       need_time;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [ID_W-1:0]         run_id;
    logic signed [PRI_W-1:0] run_priority;
    logic [TIME_W-1:0]       run_time;
    logic [TIME_W-1:0]       run_need;
    logic [QCOUNT_W-1:0]     queue_count;
  } out_res_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic reins;
    logic emit;
  } dps_cmd_t;

  typedef struct packed {
    logic need_reins;
  } dps_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/dps_ctrl.sv
// Sequencing state machine of the scheduler: request intake, execution and result hand-off.
`default_nettype none
module dps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  dps_pkg::dps_sts_t     sts,
  output dps_pkg::dps_cmd_t     cmd
);
  import dps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_REINS, S_EMIT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_EMIT) && out_free);
  assign out_valid = out_valid_r;

  assign cmd.load_req = in_valid && in_ready;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.reins    = (state_r == S_REINS);
  assign cmd.emit     = (state_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= sts.need_reins ? S_REINS : S_EMIT;
        end
        S_REINS: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // The next request may be taken in the same cycle as the result leaves.
          if (out_free) begin
            state_r <= in_valid ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dps_queue.sv
// Datapath of the scheduler: sorted shift-register ready queue, request and result registers.
`default_nettype none
module dps_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  dps_pkg::in_req_t   in_req,
  input  dps_pkg::dps_cmd_t  cmd,
  output dps_pkg::dps_sts_t  sts,
  output dps_pkg::out_res_t  out_res
);
  import dps_pkg::*;

  in_req_t                 req_r, req_nxt;
  out_res_t                res_r, res_nxt;
  out_res_t                out_r, out_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic [ID_W-1:0]         id_r   [DEPTH];
  logic signed [PRI_W-1:0] pri_r  [DEPTH];
  logic [TIME_W-1:0]       need_r [DEPTH];
  logic [TIME_W-1:0]       el_r   [DEPTH];

  logic [ID_W-1:0]         id_nxt   [DEPTH];
  logic signed [PRI_W-1:0] pri_nxt  [DEPTH];
  logic [TIME_W-1:0]       need_nxt [DEPTH];
  logic [TIME_W-1:0]       el_nxt   [DEPTH];

  // Queue contents after an insertion and after a pop of the head.
  logic [ID_W-1:0]         id_ins   [DEPTH];
  logic signed [PRI_W-1:0] pri_ins  [DEPTH];
  logic [TIME_W-1:0]       need_ins [DEPTH];
  logic [TIME_W-1:0]       el_ins   [DEPTH];
  logic [ID_W-1:0]         id_pop   [DEPTH];
  logic signed [PRI_W-1:0] pri_pop  [DEPTH];
  logic [TIME_W-1:0]       need_pop [DEPTH];
  logic [TIME_W-1:0]       el_pop   [DEPTH];

  logic [ID_W-1:0]         new_id;
  logic signed [PRI_W-1:0] new_pri;
  logic [TIME_W-1:0]       new_need;
  logic [TIME_W-1:0]       new_el;
  logic signed [PRI_W-1:0] aged_pri;

  logic [DEPTH-1:0]        stay;
  logic                    to_front;
  logic                    q_full;
  logic                    q_empty;
  logic [TIME_W-1:0]       head_el_inc;
  logic                    head_done;
  logic [CNT_W+QCOUNT_W-1:0] cnt_ext;

  assign q_full      = (count_r == CNT_W'(DEPTH));
  assign q_empty     = (count_r == '0);
  assign head_el_inc = el_r[0] + TIME_W'(1);
  assign head_done   = (head_el_inc >= need_r[0]);
  assign cnt_ext     = {{QCOUNT_W{1'b0}}, count_r};

  assign sts.need_reins = (req_r.cmd == CMD_RUN) && !q_empty && !head_done;
  assign out_res        = out_r;

  assign aged_pri = (res_r.run_priority == PRI_MIN) ? res_r.run_priority
                                                    : res_r.run_priority - PRI_W'(1);

  // A new request enters with no slices run; a requeued process carries its history.
  always_comb begin
    if (cmd.reins) begin
      new_id   = res_r.run_id;
      new_pri  = aged_pri;
      new_need = res_r.run_need;
      new_el   = res_r.run_time;
    end else begin
      new_id   = req_r.proc_id;
      new_pri  = req_r.priority_req;
      new_need = req_r.need_time;
      new_el   = '0;
    end
  end

  // Every occupied cell compares against the newcomer at once. The queue is kept sorted,
  // so the cells that stay ahead form a prefix; equal to the head still goes to the front.
  assign to_front = q_empty || (new_pri >= pri_r[0]);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = !to_front && (CNT_W'(i) < count_r) && (pri_r[i] >= new_pri);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (stay[i]) begin
        id_ins[i]   = id_r[i];
        pri_ins[i]  = pri_r[i];
        need_ins[i] = need_r[i];
        el_ins[i]   = el_r[i];
      end else if (i == 0) begin
        id_ins[i]   = new_id;
        pri_ins[i]  = new_pri;
        need_ins[i] = new_need;
        el_ins[i]   = new_el;
      end else if (stay[i-1]) begin
        id_ins[i]   = new_id;
        pri_ins[i]  = new_pri;
        need_ins[i] = new_need;
        el_ins[i]   = new_el;
      end else begin
        id_ins[i]   = id_r[i-1];
        pri_ins[i]  = pri_r[i-1];
        need_ins[i] = need_r[i-1];
        el_ins[i]   = el_r[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i < DEPTH - 1) begin
        id_pop[i]   = id_r[i+1];
        pri_pop[i]  = pri_r[i+1];
        need_pop[i] = need_r[i+1];
        el_pop[i]   = el_r[i+1];
      end else begin
        id_pop[i]   = id_r[i];
        pri_pop[i]  = pri_r[i];
        need_pop[i] = need_r[i];
        el_pop[i]   = el_r[i];
      end
    end
  end

  always_comb begin
    req_nxt   = req_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    count_nxt = count_r;
    id_nxt    = id_r;
    pri_nxt   = pri_r;
    need_nxt  = need_r;
    el_nxt    = el_r;

    if (cmd.load_req) begin
      req_nxt = in_req;
    end

    if (cmd.emit) begin
      out_nxt             = res_r;
      out_nxt.queue_count = cnt_ext[QCOUNT_W-1:0];
    end

    if (cmd.exec) begin
      res_nxt = '0;
      if (req_r.cmd == CMD_ADD) begin
        if (q_full) begin
          res_nxt.status = STAT_FULL;
        end else begin
          res_nxt.status = STAT_ADDED;
          id_nxt         = id_ins;
          pri_nxt        = pri_ins;
          need_nxt       = need_ins;
          el_nxt         = el_ins;
          count_nxt      = count_r + CNT_W'(1);
        end
      end else if (q_empty) begin
        res_nxt.status = STAT_EMPTY;
      end else begin
        res_nxt.status       = head_done ? STAT_FINISHED : STAT_REQUEUED;
        res_nxt.run_id       = id_r[0];
        res_nxt.run_priority = pri_r[0];
        res_nxt.run_time     = head_el_inc;
        res_nxt.run_need     = need_r[0];
        id_nxt               = id_pop;
        pri_nxt              = pri_pop;
        need_nxt             = need_pop;
        el_nxt               = el_pop;
        count_nxt            = count_r - CNT_W'(1);
      end
    end

    // The popped slot is free again, so the reinsertion always finds room.
    if (cmd.reins) begin
      id_nxt    = id_ins;
      pri_nxt   = pri_ins;
      need_nxt  = need_ins;
      el_nxt    = el_ins;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    id_r   <= id_nxt;
    pri_r  <= pri_nxt;
    need_r <= need_nxt;
    el_r   <= el_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dynamic_priority_scheduler_top.sv
// Top level of the dynamic priority scheduler: controller and queue datapath.
//
// Keeps a ready queue of up to DEPTH (16) processes in a sorted shift-register queue, highest
// priority at the head. An add request inserts a process; a run request dispatches the head
// for one slice and, unless it has finished, ages its priority by one and reinserts it. Every
// request gives exactly one result. An add, a rejected add, a run on an empty queue and a run
// that finishes pass through the execute and emit states, back to back; a run that requeues
// adds the reinsertion state between them, a pass through the queue cells after the pop. The
// result sits in an output register; the next request is taken while it waits to be collected.
`default_nettype none
module dynamic_priority_scheduler_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  dps_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  wire logic         out_ready,
  output dps_pkg::out_res_t out_res
);
  import dps_pkg::*;

  dps_cmd_t cmd;
  dps_sts_t sts;

  dps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule
`default_nettype wire

FILE: rtl/core/dps_checker.sv
// Port-level assertions of the scheduler and their binding to the top level.
`default_nettype none
`include "dynamic_priority_scheduler_top_assert.svh"
module dps_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input dps_pkg::out_res_t out_res
);
  import dps_pkg::*;

  `DPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_res))
  `DPS_ASSERT_IMPLY(a_full_count, out_valid && (out_res.status == STAT_FULL), out_res.queue_count == QCOUNT_W'(DEPTH))
  `DPS_ASSERT_IMPLY(a_empty_count, out_valid && (out_res.status == STAT_EMPTY), out_res.queue_count == '0)
  `DPS_ASSERT_IMPLY(a_finish_time, out_valid && (out_res.status == STAT_FINISHED), out_res.run_time >= out_res.run_need)

endmodule

bind dynamic_priority_scheduler_top dps_checker u_dps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_res   (out_res)
);
`default_nettype wire
